[src/aes128_cbc_cipher_defines.svh]
// Assertion macros for the AES-128 CBC cipher checker.
// No dependencies; included by the checker file.
`ifndef AES128_CBC_CIPHER_DEFINES_SVH
`define AES128_CBC_CIPHER_DEFINES_SVH

// same-cycle implication
`define AESC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aesc assertion failed");

// next-cycle implication
`define AESC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aesc assertion failed");

`endif

[src/aesc_pkg.sv]
// Shared types, constants and byte tables for the AES-128 CBC cipher.
// No dependencies.
package aesc_pkg;

   localparam int RK_ROWS = 11;
   localparam int RK_AW   = 4;
   localparam logic [3:0] NUM_ROUNDS = 4'd10;

   localparam logic CSR_KEY_HI = 1'b0;
   localparam logic CSR_KEY_LO = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic             we;
      logic [RK_AW-1:0] addr;
      logic [127:0]     data;
   } rk_wr_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // multiply by x in GF(2^8), polynomial 0x11B
   function automatic logic [7:0] xt(input logic [7:0] a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

[src/aesc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aesc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[src/aesc_key_exp.sv]
// AES-128 key schedule: one 128-bit round key per cycle into the key RAM.
// Depends on aesc_pkg.
module aesc_key_exp
   import aesc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [127:0]  key,
   output logic          busy,
   output rk_wr_type     wr
);

   logic [127:0]     rk_ff, rk_in;
   logic [7:0]       rcon_ff, rcon_in;
   logic [RK_AW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [31:0]      t;
   logic [127:0]     nxt;

   always_comb begin
      t = {SBOX[rk_ff[23:16]], SBOX[rk_ff[15:8]], SBOX[rk_ff[7:0]], SBOX[rk_ff[31:24]]}
          ^ {rcon_ff, 24'h0};
      nxt[127:96] = rk_ff[127:96] ^ t;
      nxt[95:64]  = rk_ff[95:64] ^ nxt[127:96];
      nxt[63:32]  = rk_ff[63:32] ^ nxt[95:64];
      nxt[31:0]   = rk_ff[31:0] ^ nxt[63:32];
   end

   always_comb begin
      rk_in   = rk_ff;
      rcon_in = rcon_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      wr.we   = 1'b0;
      wr.addr = cnt_ff + 1'b1;
      wr.data = nxt;
      if (start) begin
         rk_in   = key;
         rcon_in = 8'h01;
         cnt_in  = '0;
         busy_in = 1'b1;
         wr.we   = 1'b1;
         wr.addr = '0;
         wr.data = key;
      end else if (busy_ff) begin
         rk_in   = nxt;
         rcon_in = xt(rcon_ff);
         cnt_in  = cnt_ff + 1'b1;
         wr.we   = 1'b1;
         if (cnt_in == RK_AW'(RK_ROWS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rk_ff   <= rk_in;
      rcon_ff <= rcon_in;
   end

   assign busy = busy_ff;

endmodule

[src/aesc_round.sv]
// One AES round, forward or inverse, shared over all ten rounds.
// Depends on aesc_pkg.
module aesc_round
   import aesc_pkg::*;
(
   input  logic [127:0] state,
   input  logic [127:0] rk,
   input  logic         decrypt,
   input  logic         last,
   output logic [127:0] result
);

   logic [7:0] s [16];
   logic [7:0] a [16];
   logic [7:0] b [16];
   logic [7:0] m [16];
   logic [7:0] k [16];
   logic [7:0] x0, x1, x2, x3;
   logic [7:0] e0, e1, e2, e3;

   // GF multiplies for the inverse mix
   function automatic logic [7:0] m9(input logic [7:0] v);
      m9 = xt(xt(xt(v))) ^ v;
   endfunction
   function automatic logic [7:0] m11(input logic [7:0] v);
      m11 = xt(xt(xt(v))) ^ xt(v) ^ v;
   endfunction
   function automatic logic [7:0] m13(input logic [7:0] v);
      m13 = xt(xt(xt(v))) ^ xt(xt(v)) ^ v;
   endfunction
   function automatic logic [7:0] m14(input logic [7:0] v);
      m14 = xt(xt(xt(v))) ^ xt(xt(v)) ^ xt(v);
   endfunction

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state[127-8*i -: 8];
         k[i] = rk[127-8*i -: 8];
      end
      // shift rows then sub bytes (order is free: both are bytewise moves/maps)
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (decrypt) begin
               a[r+4*c] = INV_SBOX[s[r+4*((c-r+4)%4)]];
            end else begin
               a[r+4*c] = SBOX[s[r+4*((c+r)%4)]];
            end
         end
      end
      // inverse round adds the key before the mix
      for (int i = 0; i < 16; i++) begin
         b[i] = decrypt ? (a[i] ^ k[i]) : a[i];
      end
      for (int c = 0; c < 4; c++) begin
         x0 = b[4*c];
         x1 = b[4*c+1];
         x2 = b[4*c+2];
         x3 = b[4*c+3];
         if (decrypt) begin
            e0 = m14(x0) ^ m11(x1) ^ m13(x2) ^ m9(x3);
            e1 = m9(x0) ^ m14(x1) ^ m11(x2) ^ m13(x3);
            e2 = m13(x0) ^ m9(x1) ^ m14(x2) ^ m11(x3);
            e3 = m11(x0) ^ m13(x1) ^ m9(x2) ^ m14(x3);
         end else begin
            e0 = xt(x0) ^ xt(x1) ^ x1 ^ x2 ^ x3;
            e1 = x0 ^ xt(x1) ^ xt(x2) ^ x2 ^ x3;
            e2 = x0 ^ x1 ^ xt(x2) ^ xt(x3) ^ x3;
            e3 = xt(x0) ^ x0 ^ x1 ^ x2 ^ xt(x3);
         end
         m[4*c]   = last ? x0 : e0;
         m[4*c+1] = last ? x1 : e1;
         m[4*c+2] = last ? x2 : e2;
         m[4*c+3] = last ? x3 : e3;
      end
      for (int i = 0; i < 16; i++) begin
         result[127-8*i -: 8] = decrypt ? m[i] : (m[i] ^ k[i]);
      end
   end

endmodule

[src/aes128_cbc_cipher.sv]
// AES-128 CBC cipher top level: sequencer, chaining register, output register.
// Depends on aesc_pkg, aesc_ram, aesc_key_exp, aesc_round.
//
//  channel | dir | handshake        | payload
//  req     | in  | tvalid / tready  | tdata: block, IV, byte count; tuser: first, decrypt
//  rsp     | out | tvalid / tready  | tdata: result block, byte count
//  csr     | in  | csr_we           | csr_index, csr_wdata (key halves)
//
// An item goes from accept to the output register through the initial key
// add (its key row is read at accept), ten passes through the shared round
// unit, then the output load. The next request can be taken the cycle after that
// load, so the request side takes no new block until the last is through.
// Reset (synchronous, high) and every key write run the key schedule, with
// req_tready low meanwhile. A stalled result holds in the output register; the
// sequencer waits in its finish state only if an older result is still unread.
module aes128_cbc_cipher
   import aesc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // data_hi[63:0], data_lo[127:64], iv_hi[191:128], iv_lo[255:192],
   // valid_bytes[260:256], zero [263:261]
   input  logic [263:0]  req_tdata,
   // first_block[0], decrypt_dir[1]
   input  logic [1:0]    req_tuser,
   input  logic          req_tvalid,
   output logic          req_tready,
   // out_hi[63:0], out_lo[127:64], out_bytes[132:128], zero [135:133]
   output logic [135:0]  rsp_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [63:0]   csr_wdata
);

   seq_state_type    state_ff, state_in;
   logic [3:0]       rnd_ff, rnd_in;
   logic [127:0]     key_ff;
   logic             kick_ff;
   logic [127:0]     chain_ff, ct_ff, blk_ff, mask_ff;
   logic             dir_ff;
   logic [4:0]       n_ff;
   logic [127:0]     out_ff;
   logic [4:0]       outb_ff;
   logic             rsp_valid_ff;

   logic             busy;
   rk_wr_type        rk_wr;
   logic [RK_AW-1:0] rd_addr;
   logic [127:0]     rk_data;
   logic [127:0]     round_out;

   logic             req_fire, out_free, out_load;
   logic [127:0]     data_in, iv_in, chain_eff, mask_in;
   logic [4:0]       n_in;
   logic [3:0]       addr_round;
   logic             addr_dir;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // byte 0 is the most significant byte of the block
   assign data_in = {req_tdata[63:0], req_tdata[127:64]};
   assign iv_in   = {req_tdata[191:128], req_tdata[255:192]};

   // count of 0 or above 16 means a full block
   always_comb begin
      n_in = req_tdata[260:256];
      if (n_in == 5'd0 || n_in > 5'd16) begin
         n_in = 5'd16;
      end
      for (int i = 0; i < 16; i++) begin
         mask_in[127-8*i -: 8] = (5'(i) < n_in) ? 8'hff : 8'h00;
      end
      chain_eff = req_tuser[0] ? iv_in : chain_ff;
   end

   // key schedule and round-key RAM
   aesc_key_exp u_key_exp (
      .clock (clock),
      .reset (reset),
      .start (kick_ff),
      .key   (key_ff),
      .busy  (busy),
      .wr    (rk_wr)
   );

   aesc_ram #(
      .WIDTH (128),
      .DEPTH (RK_ROWS)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (rk_wr.we),
      .wr_addr (rk_wr.addr),
      .wr_data (rk_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rk_data)
   );

   aesc_round u_round (
      .state   (blk_ff),
      .rk      (rk_data),
      .decrypt (dir_ff),
      .last    (rnd_ff == NUM_ROUNDS),
      .result  (round_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_ROUND;
         ST_ROUND:  if (rnd_ff == NUM_ROUNDS) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs; key rows are fetched one round ahead
   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      addr_round = 4'd0;
      addr_dir   = dir_ff;
      rnd_in     = rnd_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !kick_ff && !busy;
            addr_dir   = req_tuser[1];
         end
         ST_LOAD: begin
            addr_round = 4'd1;
            rnd_in     = 4'd1;
         end
         ST_ROUND: begin
            addr_round = (rnd_ff < NUM_ROUNDS) ? rnd_ff + 4'd1 : NUM_ROUNDS;
            rnd_in     = rnd_ff + 4'd1;
         end
         ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      rd_addr = RK_AW'(addr_dir ? NUM_ROUNDS - addr_round : addr_round);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         kick_ff      <= 1'b1;
         key_ff       <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         kick_ff  <= csr_we;
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_HI: key_ff[127:64] <= csr_wdata;
               CSR_KEY_LO: key_ff[63:0]   <= csr_wdata;
               default:    key_ff         <= key_ff;
            endcase
         end
         if (req_fire) begin
            chain_ff <= chain_eff;
         end else if (out_load) begin
            chain_ff <= dir_ff ? ct_ff : blk_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // payload
      if (req_fire) begin
         dir_ff  <= req_tuser[1];
         n_ff    <= n_in;
         mask_ff <= mask_in;
         ct_ff   <= data_in & mask_in;
         blk_ff  <= req_tuser[1] ? (data_in & mask_in)
                                 : ((data_in ^ chain_eff) & mask_in);
      end else if (state_ff == ST_LOAD) begin
         blk_ff <= blk_ff ^ rk_data;
      end else if (state_ff == ST_ROUND) begin
         blk_ff <= round_out;
      end
      if (out_load) begin
         out_ff  <= dir_ff ? ((blk_ff ^ chain_ff) & mask_ff) : blk_ff;
         outb_ff <= dir_ff ? n_ff : 5'd16;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, outb_ff, out_ff[63:0], out_ff[127:64]};

endmodule

[src/aesc_checker.sv]
// Port-level assertions for the AES-128 CBC cipher, bound to the top level.
// Depends on aes128_cbc_cipher_defines.svh.
`include "aes128_cbc_cipher_defines.svh"

module aesc_checker (
   input logic          clock,
   input logic          reset,
   input logic [263:0]  req_tdata,
   input logic [1:0]    req_tuser,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic [135:0]  rsp_tdata,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic          csr_we,
   input logic          csr_index,
   input logic [63:0]   csr_wdata
);

   `AESC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `AESC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `AESC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `AESC_ASSERT_NEXT(a_busy_after_key, clock, reset, csr_we, !req_tready)
   `AESC_ASSERT_NOW(a_rsp_count, clock, reset, rsp_tvalid,
                    rsp_tdata[132:128] != 5'd0 && rsp_tdata[132:128] <= 5'd16)

endmodule

bind aes128_cbc_cipher aesc_checker u_aesc_checker (.*);

[tb/aes128_cbc_cipher_test.sv]
// Self-checking testbench for the AES-128 CBC cipher: random requests, key changes.
// Depends on aesc_pkg and aes128_cbc_cipher.
`timescale 1ns / 1ps

module aes128_cbc_cipher_test;
   import aesc_pkg::*;

   typedef struct packed {
      logic [63:0] data_hi;
      logic [63:0] data_lo;
      logic [63:0] iv_hi;
      logic [63:0] iv_lo;
      logic        first_block;
      logic        decrypt_dir;
      logic [4:0]  valid_bytes;
   } cbc_req_type;

   typedef struct packed {
      logic [63:0] out_hi;
      logic [63:0] out_lo;
      logic [4:0]  out_bytes;
   } cbc_rsp_type;

   logic          clock = 0;
   logic          reset = 1;
   logic [263:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [135:0]  rsp_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic          csr_we = 0;
   logic          csr_index = CSR_KEY_HI;
   logic [63:0]   csr_wdata = '0;

   aes128_cbc_cipher dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state: key, expanded round keys, chaining register
   logic [63:0]  key_hi_m, key_lo_m;
   logic [31:0]  rkey [44];
   logic [127:0] chain_m;

   cbc_req_type  pending_reqs[$];
   cbc_rsp_type  expected_rsps[$];
   int           mismatches = 0;
   bit           quiet_idle = 0;
   bit           req_acc = 0;

   // GF(2^8) helpers, computed arithmetically rather than from tables
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] a);
      logic [7:0] r, p;
      r = 1;
      p = a;
      for (int e = 0; e < 8; e++) begin
         if (e != 0) r = gmul(r, p);
         p = gmul(p, p);
      end
      return r;   // a^254 = product of a^2..a^128
   endfunction

   function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
      return (x << n) | (x >> (8 - n));
   endfunction

   function automatic logic [7:0] fwd_sub(input logic [7:0] x);
      logic [7:0] y;
      y = ginv(x);
      return y ^ rol8(y, 1) ^ rol8(y, 2) ^ rol8(y, 3) ^ rol8(y, 4) ^ 8'h63;
   endfunction

   function automatic logic [7:0] rev_sub(input logic [7:0] y);
      return ginv(rol8(y, 1) ^ rol8(y, 3) ^ rol8(y, 6) ^ 8'h05);
   endfunction

   task automatic expand_round_keys();
      logic [7:0]  rc;
      logic [31:0] t;
      rc = 1;
      rkey[0] = key_hi_m[63:32];
      rkey[1] = key_hi_m[31:0];
      rkey[2] = key_lo_m[63:32];
      rkey[3] = key_lo_m[31:0];
      for (int i = 4; i < 44; i++) begin
         t = rkey[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_sub(t[31:24]), fwd_sub(t[23:16]), fwd_sub(t[15:8]),
                 fwd_sub(t[7:0])} ^ {rc, 24'h0};
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end
         rkey[i] = rkey[i-4] ^ t;
      end
   endtask

   // state bytes: s[i] is block byte i, byte 0 most significant of the 128-bit word
   typedef logic [7:0] blk_type [16];

   function automatic blk_type to_blk(input logic [127:0] v);
      blk_type b;
      for (int i = 0; i < 16; i++) b[i] = v[127-8*i -: 8];
      return b;
   endfunction

   function automatic logic [127:0] from_blk(input blk_type b);
      logic [127:0] v;
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = b[i];
      return v;
   endfunction

   function automatic blk_type add_rk(input blk_type s, input int r);
      for (int c = 0; c < 4; c++)
         for (int j = 0; j < 4; j++) s[4*c+j] ^= rkey[4*r+c][31-8*j -: 8];
      return s;
   endfunction

   function automatic blk_type rows_shift(input blk_type s, input bit inv);
      blk_type t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            if (inv) t[r + 4*((c+r)%4)] = s[r+4*c];
            else t[r+4*c] = s[r + 4*((c+r)%4)];
      return t;
   endfunction

   function automatic blk_type cols_mix(input blk_type s, input bit inv);
      logic [7:0] m [4];
      logic [7:0] a [4];
      logic [7:0] v;
      if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
      else m = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
         for (int r = 0; r < 4; r++) begin
            v = 0;
            for (int k = 0; k < 4; k++) v ^= gmul(m[(k-r+4)%4], a[k]);
            s[4*c+r] = v;
         end
      end
      return s;
   endfunction

   function automatic blk_type bytes_sub(input blk_type s, input bit inv);
      for (int i = 0; i < 16; i++) s[i] = inv ? rev_sub(s[i]) : fwd_sub(s[i]);
      return s;
   endfunction

   // one CBC step: updates the chaining register, returns the result
   function automatic cbc_rsp_type cbc_step(input cbc_req_type q);
      blk_type      s, cb;
      int           n;
      cbc_rsp_type  o;
      logic [127:0] ct;
      n = q.valid_bytes;
      if (n == 0 || n > 16) n = 16;   // out-of-range count means a full block
      if (q.first_block) chain_m = {q.iv_hi, q.iv_lo};
      s = to_blk({q.data_hi, q.data_lo});
      for (int i = n; i < 16; i++) s[i] = 0;
      cb = to_blk(chain_m);
      if (!q.decrypt_dir) begin
         // only counted bytes see the chain; padding goes in as plain zeros
         for (int i = 0; i < n; i++) s[i] ^= cb[i];
         s = add_rk(s, 0);
         for (int r = 1; r < 10; r++)
            s = add_rk(cols_mix(rows_shift(bytes_sub(s, 0), 0), 0), r);
         s = add_rk(rows_shift(bytes_sub(s, 0), 0), 10);
         chain_m = from_blk(s);
         o.out_bytes = 5'd16;
      end else begin
         ct = from_blk(s);
         s = add_rk(s, 10);
         for (int r = 9; r > 0; r--)
            s = cols_mix(add_rk(bytes_sub(rows_shift(s, 1), 1), r), 1);
         s = add_rk(bytes_sub(rows_shift(s, 1), 1), 0);
         for (int i = 0; i < 16; i++) s[i] = (i < n) ? (s[i] ^ cb[i]) : 8'h00;
         chain_m = ct;
         o.out_bytes = 5'(n);
      end
      {o.out_hi, o.out_lo} = from_blk(s);
      return o;
   endfunction

   // predict at acceptance
   always @(posedge clock) begin
      req_acc = !reset && req_tvalid && req_tready;
      if (req_acc)
         expected_rsps.push_back(cbc_step(pending_reqs.pop_front()));
   end

   // driver: presents queued requests, holds a waiting one until taken
   always @(negedge clock) begin
      cbc_req_type q;
      if (!reset) begin
         if (req_tvalid && !req_acc) begin
            // still waiting: keep valid and data as they are
         end else if (pending_reqs.size() > 0 &&
                      (quiet_idle || $urandom_range(99) >= 8)) begin
            q = pending_reqs[0];
            req_tdata <= {3'b0, q.valid_bytes, q.iv_lo, q.iv_hi, q.data_lo, q.data_hi};
            req_tuser <= {q.decrypt_dir, q.first_block};
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
         rsp_tready <= quiet_idle || ($urandom_range(99) >= 8);
      end
   end

   // monitor: compares each result with the oldest expectation
   always @(posedge clock) begin
      cbc_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_hi = rsp_tdata[63:0];
         got.out_lo = rsp_tdata[127:64];
         got.out_bytes = rsp_tdata[132:128];
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hi %h lo %h n %0d, got hi %h lo %h n %0d",
                           want.out_hi, want.out_lo, want.out_bytes,
                           got.out_hi, got.out_lo, got.out_bytes);
            end
         end
      end
   end

   task automatic write_key(input logic idx, input logic [63:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      if (idx == CSR_KEY_HI) key_hi_m = v;
      else key_lo_m = v;
      expand_round_keys();
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic cbc_req_type mk_req(input bit first, input bit dec, input int n);
      cbc_req_type q;
      q.data_hi = rnd64();
      q.data_lo = rnd64();
      q.iv_hi = rnd64();
      q.iv_lo = rnd64();
      q.first_block = first;
      q.decrypt_dir = dec;
      q.valid_bytes = 5'(n);
      return q;
   endfunction

   // wait for the block to go idle before a key write
   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      cbc_req_type q;
      int msg_len;
      bit dec;
      key_hi_m = 0;
      key_lo_m = 0;
      chain_m = 0;
      expand_round_keys();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: chain from reset without a first block, then field extremes
      q = mk_req(0, 0, 16);
      pending_reqs.push_back(q);
      q = mk_req(0, 1, 16);
      pending_reqs.push_back(q);
      q = '0; q.first_block = 1; q.valid_bytes = 16;
      pending_reqs.push_back(q);
      q = '1; q.valid_bytes = 16;
      pending_reqs.push_back(q);
      q = '1; q.decrypt_dir = 1; q.valid_bytes = 16;
      pending_reqs.push_back(q);
      // short blocks, count of 1, and out-of-range counts 0, 17, 31
      pending_reqs.push_back(mk_req(1, 0, 1));
      pending_reqs.push_back(mk_req(0, 0, 15));
      pending_reqs.push_back(mk_req(1, 1, 1));
      pending_reqs.push_back(mk_req(0, 1, 7));
      pending_reqs.push_back(mk_req(1, 0, 0));
      pending_reqs.push_back(mk_req(0, 1, 17));
      pending_reqs.push_back(mk_req(0, 0, 31));
      pending_reqs.push_back(mk_req(1, 1, 0));
      drain();

      write_key(CSR_KEY_HI, '1);
      write_key(CSR_KEY_LO, '1);
      pending_reqs.push_back(mk_req(1, 0, 16));
      pending_reqs.push_back(mk_req(0, 1, 9));
      drain();

      // random phases, a new key between each
      for (int ph = 0; ph < 6; ph++) begin
         write_key(CSR_KEY_HI, rnd64());
         write_key(CSR_KEY_LO, rnd64());
         quiet_idle = (ph == 3);
         for (int k = 0; k < 300; ) begin
            if ($urandom_range(9) == 0) begin
               // noise: odd counts, stray first blocks, mixed directions
               pending_reqs.push_back(mk_req($urandom_range(1), $urandom_range(1),
                                             $urandom_range(31)));
               k++;
            end else begin
               // well-formed message: first block, full blocks, maybe short tail
               msg_len = $urandom_range(1, 8);
               dec = $urandom_range(1);
               for (int b = 0; b < msg_len; b++) begin
                  pending_reqs.push_back(mk_req(b == 0, dec,
                     (b == msg_len - 1 && $urandom_range(1)) ? $urandom_range(1, 16) : 16));
                  k++;
               end
            end
         end
         drain();
      end
      quiet_idle = 0;
      drain();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
